[rtl/wfht_pkg.sv]
`timescale 1ns / 1ps

package wfht_pkg;

  // Coordinate width of the pointer and of the outer rectangle edges.
  localparam int COORD_WIDTH  = 16;
  localparam int SIZE_WIDTH   = COORD_WIDTH - 1;
  // Four extra bits cover the scroll bar, menu, caption and button offsets.
  localparam int EXT_WIDTH    = COORD_WIDTH + 4;
  localparam int METRIC_WIDTH = 8;
  localparam int STYLE_WIDTH  = 8;

  localparam int ADDR_WIDTH   = 5;
  localparam int DATA_WIDTH   = 32;
  localparam int IDX_WIDTH    = 3;

  // Register indexes; the byte address is four times the index.
  localparam logic [IDX_WIDTH-1:0] REG_VSCROLL_WIDTH  = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_HSCROLL_HEIGHT = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_MENU_HEIGHT    = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_CAPTION_HEIGHT = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_BUTTON_WIDTH   = 3'd4;
  localparam logic [IDX_WIDTH-1:0] REG_CORNER_HEIGHT  = 3'd5;

  localparam logic [METRIC_WIDTH-1:0] RST_VSCROLL_WIDTH  = 8'd16;
  localparam logic [METRIC_WIDTH-1:0] RST_HSCROLL_HEIGHT = 8'd16;
  localparam logic [METRIC_WIDTH-1:0] RST_MENU_HEIGHT    = 8'd18;
  localparam logic [METRIC_WIDTH-1:0] RST_CAPTION_HEIGHT = 8'd20;
  localparam logic [METRIC_WIDTH-1:0] RST_BUTTON_WIDTH   = 8'd18;
  localparam logic [METRIC_WIDTH-1:0] RST_CORNER_HEIGHT  = 8'd18;

  // Bit positions within style_flags.
  localparam int ST_VSCROLL  = 0;
  localparam int ST_HSCROLL  = 1;
  localparam int ST_BORDER   = 2;
  localparam int ST_DLGFRAME = 3;
  localparam int ST_SYSMENU  = 4;
  localparam int ST_MAXBOX   = 5;
  localparam int ST_MINBOX   = 6;
  localparam int ST_THICK    = 7;

  typedef logic signed [EXT_WIDTH-1:0] ext_t;

  typedef enum logic [4:0] {
    HIT_ERROR        = 5'd0,
    HIT_NOWHERE      = 5'd1,
    HIT_CLIENT       = 5'd2,
    HIT_VSCROLL      = 5'd3,
    HIT_HSCROLL      = 5'd4,
    HIT_SIZEBOX      = 5'd5,
    HIT_MENU         = 5'd6,
    HIT_SYSMENU      = 5'd7,
    HIT_MAXBUTTON    = 5'd8,
    HIT_MINBUTTON    = 5'd9,
    HIT_CAPTION      = 5'd10,
    HIT_BORDER       = 5'd11,
    HIT_LEFT         = 5'd12,
    HIT_RIGHT        = 5'd13,
    HIT_TOP          = 5'd14,
    HIT_TOPLEFT      = 5'd15,
    HIT_TOPRIGHT     = 5'd16,
    HIT_BOTTOM       = 5'd17,
    HIT_BOTTOMLEFT   = 5'd18,
    HIT_BOTTOMRIGHT  = 5'd19
  } hit_code_t;

  typedef struct packed {
    logic [METRIC_WIDTH-1:0] vscroll_width;
    logic [METRIC_WIDTH-1:0] hscroll_height;
    logic [METRIC_WIDTH-1:0] menu_height;
    logic [METRIC_WIDTH-1:0] caption_height;
    logic [METRIC_WIDTH-1:0] button_width;
    logic [METRIC_WIDTH-1:0] corner_height;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] outer_left;
    logic signed [COORD_WIDTH-1:0] outer_top;
    logic signed [COORD_WIDTH-1:0] outer_right;
    logic signed [COORD_WIDTH-1:0] outer_bottom;
    logic [SIZE_WIDTH-1:0]         client_width;
    logic [SIZE_WIDTH-1:0]         client_height;
    logic [STYLE_WIDTH-1:0]        style_flags;
    logic                          has_menu;
    logic                          is_captured;
  } item_t;

endpackage

[rtl/wfht_cfg.sv]
`timescale 1ns / 1ps

module wfht_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wfht_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [wfht_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [wfht_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                              pready,
  output wfht_pkg::cfg_t                    cfg
);

  logic                                  wr_en;
  logic [wfht_pkg::IDX_WIDTH-1:0]        idx;
  logic [wfht_pkg::METRIC_WIDTH-1:0]     wdata;
  logic [wfht_pkg::METRIC_WIDTH-1:0]     rdata;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[wfht_pkg::ADDR_WIDTH-1:2];
  assign wdata  = pwdata[wfht_pkg::METRIC_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vscroll_width  <= wfht_pkg::RST_VSCROLL_WIDTH;
      cfg.hscroll_height <= wfht_pkg::RST_HSCROLL_HEIGHT;
      cfg.menu_height    <= wfht_pkg::RST_MENU_HEIGHT;
      cfg.caption_height <= wfht_pkg::RST_CAPTION_HEIGHT;
      cfg.button_width   <= wfht_pkg::RST_BUTTON_WIDTH;
      cfg.corner_height  <= wfht_pkg::RST_CORNER_HEIGHT;
    end else if (wr_en) begin
      case (idx)
        wfht_pkg::REG_VSCROLL_WIDTH:  cfg.vscroll_width  <= wdata;
        wfht_pkg::REG_HSCROLL_HEIGHT: cfg.hscroll_height <= wdata;
        wfht_pkg::REG_MENU_HEIGHT:    cfg.menu_height    <= wdata;
        wfht_pkg::REG_CAPTION_HEIGHT: cfg.caption_height <= wdata;
        wfht_pkg::REG_BUTTON_WIDTH:   cfg.button_width   <= wdata;
        wfht_pkg::REG_CORNER_HEIGHT:  cfg.corner_height  <= wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      wfht_pkg::REG_VSCROLL_WIDTH:  rdata = cfg.vscroll_width;
      wfht_pkg::REG_HSCROLL_HEIGHT: rdata = cfg.hscroll_height;
      wfht_pkg::REG_MENU_HEIGHT:    rdata = cfg.menu_height;
      wfht_pkg::REG_CAPTION_HEIGHT: rdata = cfg.caption_height;
      wfht_pkg::REG_BUTTON_WIDTH:   rdata = cfg.button_width;
      wfht_pkg::REG_CORNER_HEIGHT:  rdata = cfg.corner_height;
      default:                      rdata = '0;
    endcase
  end

  assign prdata = wfht_pkg::DATA_WIDTH'(rdata);

endmodule

[rtl/wfht_classify.sv]
`timescale 1ns / 1ps

module wfht_classify (
  input  wfht_pkg::item_t     item,
  input  wfht_pkg::cfg_t      cfg,
  output wfht_pkg::hit_code_t code
);

  localparam wfht_pkg::ext_t ZERO = '0;
  localparam wfht_pkg::ext_t ONE  = wfht_pkg::ext_t'(1);

  wfht_pkg::ext_t px, py, ol, ot, orr, ob, cw, ch;
  wfht_pkg::ext_t vw, hh, mh, cph, bw, crh, bw1;
  wfht_pkg::ext_t r1, b2, t3, t4, tf, rmax, rmin;
  logic vs, hs, capt_en, no_sizing;

  function automatic logic in_rect(input wfht_pkg::ext_t x, input wfht_pkg::ext_t y,
                                   input wfht_pkg::ext_t l, input wfht_pkg::ext_t t,
                                   input wfht_pkg::ext_t r, input wfht_pkg::ext_t b);
    return (x >= l) && (x < r) && (y >= t) && (y < b);
  endfunction

  // Signed fields sign-extend, sizes and metrics zero-extend.
  assign px  = wfht_pkg::ext_t'(item.point_x);
  assign py  = wfht_pkg::ext_t'(item.point_y);
  assign ol  = wfht_pkg::ext_t'(item.outer_left);
  assign ot  = wfht_pkg::ext_t'(item.outer_top);
  assign orr = wfht_pkg::ext_t'(item.outer_right);
  assign ob  = wfht_pkg::ext_t'(item.outer_bottom);
  assign cw  = wfht_pkg::ext_t'(item.client_width);
  assign ch  = wfht_pkg::ext_t'(item.client_height);
  assign vw  = wfht_pkg::ext_t'(cfg.vscroll_width);
  assign hh  = wfht_pkg::ext_t'(cfg.hscroll_height);
  assign mh  = wfht_pkg::ext_t'(cfg.menu_height);
  assign cph = wfht_pkg::ext_t'(cfg.caption_height);
  assign bw  = wfht_pkg::ext_t'(cfg.button_width);
  assign crh = wfht_pkg::ext_t'(cfg.corner_height);
  assign bw1 = bw + ONE;

  assign vs      = item.style_flags[wfht_pkg::ST_VSCROLL];
  assign hs      = item.style_flags[wfht_pkg::ST_HSCROLL];
  assign capt_en = item.style_flags[wfht_pkg::ST_BORDER] &&
                   item.style_flags[wfht_pkg::ST_DLGFRAME];
  assign no_sizing = !item.style_flags[wfht_pkg::ST_THICK] ||
                     (item.style_flags[wfht_pkg::ST_DLGFRAME] &&
                      !item.style_flags[wfht_pkg::ST_BORDER]);

  // Band edges as the client rectangle grows outward.
  assign r1   = cw + (vs ? vw : ZERO);
  assign b2   = ch + (hs ? hh : ZERO);
  assign t3   = item.has_menu ? (ZERO - mh - ONE) : ZERO;
  assign t4   = t3 - (cph - ONE);
  assign tf   = capt_en ? t4 : t3;
  assign rmax = r1 - (item.style_flags[wfht_pkg::ST_MAXBOX] ? bw1 : ZERO);
  assign rmin = rmax - (item.style_flags[wfht_pkg::ST_MINBOX] ? bw1 : ZERO);

  always_comb begin
    code = wfht_pkg::HIT_ERROR;
    if (item.is_captured) begin
      code = wfht_pkg::HIT_CLIENT;
    end else if (!in_rect(px, py, ol, ot, orr, ob)) begin
      code = wfht_pkg::HIT_NOWHERE;
    end else if (in_rect(px, py, ZERO, ZERO, cw, ch)) begin
      code = wfht_pkg::HIT_CLIENT;
    end else if (vs && in_rect(px, py, ZERO, ZERO, r1, ch)) begin
      code = wfht_pkg::HIT_VSCROLL;
    end else if (hs && in_rect(px, py, ZERO, ZERO, r1, b2)) begin
      if (vs && (px >= cw)) begin
        code = wfht_pkg::HIT_SIZEBOX;
      end else begin
        code = wfht_pkg::HIT_HSCROLL;
      end
    end else if (item.has_menu && in_rect(px, py, ZERO, t3, r1, b2)) begin
      code = wfht_pkg::HIT_MENU;
    end else if (capt_en && in_rect(px, py, ZERO, t4, r1, b2)) begin
      // The system menu button is measured from the client origin.
      if (item.style_flags[wfht_pkg::ST_SYSMENU] && (px <= bw)) begin
        code = wfht_pkg::HIT_SYSMENU;
      end else if (px >= rmax) begin
        code = wfht_pkg::HIT_MAXBUTTON;
      end else if (px >= rmin) begin
        code = wfht_pkg::HIT_MINBUTTON;
      end else begin
        code = wfht_pkg::HIT_CAPTION;
      end
    end else if (no_sizing) begin
      code = wfht_pkg::HIT_BORDER;
    end else if (py < tf) begin
      if (px < bw) begin
        code = wfht_pkg::HIT_TOPLEFT;
      end else if (px >= r1 - bw) begin
        code = wfht_pkg::HIT_TOPRIGHT;
      end else begin
        code = wfht_pkg::HIT_TOP;
      end
    end else if (py >= b2) begin
      if (px < bw) begin
        code = wfht_pkg::HIT_BOTTOMLEFT;
      end else if (px >= r1 - bw) begin
        code = wfht_pkg::HIT_BOTTOMRIGHT;
      end else begin
        code = wfht_pkg::HIT_BOTTOM;
      end
    end else if (px < ZERO) begin
      if (py < tf + crh) begin
        code = wfht_pkg::HIT_TOPLEFT;
      end else if (py >= b2 - crh) begin
        code = wfht_pkg::HIT_BOTTOMLEFT;
      end else begin
        code = wfht_pkg::HIT_LEFT;
      end
    end else if (px >= r1) begin
      if (py < tf + crh) begin
        code = wfht_pkg::HIT_TOPRIGHT;
      end else if (py >= b2 - crh) begin
        code = wfht_pkg::HIT_BOTTOMRIGHT;
      end else begin
        code = wfht_pkg::HIT_RIGHT;
      end
    end
  end

endmodule

[rtl/window_frame_hit_test_unit.sv]
`timescale 1ns / 1ps
// Window frame hit test unit.
// Each input transaction carries a pointer position, the outer window
// rectangle and client size (both relative to the client origin), style
// flags, a menu flag and a capture flag; each produces exactly one output
// transaction carrying the hit code.
// Both channels use valid and stall: a transaction completes at a clock edge
// where valid is high and stall is low. The frame metrics sit in six 8-bit
// registers behind an APB-style port at byte addresses 0, 4, ..., 20. The
// user must write them only while the unit is idle; the unit itself does
// not enforce this. The item is captured in an input register, then the
// comparison logic between that register and the output register
// classifies it. Throughput is one item per clock when out_stall is low.
// While a result waits under out_stall the input register can still take one
// more item; in_stall rises only when both registers are full.
// Reset empties both registers and restores the metric reset values.
module window_frame_hit_test_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [wfht_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [wfht_pkg::COORD_WIDTH-1:0] point_y,
  input  logic signed [wfht_pkg::COORD_WIDTH-1:0] outer_left,
  input  logic signed [wfht_pkg::COORD_WIDTH-1:0] outer_top,
  input  logic signed [wfht_pkg::COORD_WIDTH-1:0] outer_right,
  input  logic signed [wfht_pkg::COORD_WIDTH-1:0] outer_bottom,
  input  logic [wfht_pkg::SIZE_WIDTH-1:0]         client_width,
  input  logic [wfht_pkg::SIZE_WIDTH-1:0]         client_height,
  input  logic [wfht_pkg::STYLE_WIDTH-1:0]        style_flags,
  input  logic                                   has_menu,
  input  logic                                   is_captured,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [4:0]                             hit_code,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [wfht_pkg::ADDR_WIDTH-1:0]         paddr,
  input  logic [wfht_pkg::DATA_WIDTH-1:0]         pwdata,
  output logic [wfht_pkg::DATA_WIDTH-1:0]         prdata,
  output logic                                   pready
);

  wfht_pkg::cfg_t      cfg;
  wfht_pkg::item_t     item;
  wfht_pkg::hit_code_t code;
  logic                item_valid;
  logic                out_en;
  logic                item_en;

  wfht_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wfht_classify u_classify (
    .item (item),
    .cfg  (cfg),
    .code (code)
  );

  assign out_en   = !out_valid || !out_stall;
  assign item_en  = !item_valid || out_en;
  assign in_stall = !item_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (item_en) begin
        item_valid <= in_valid;
      end
      if (out_en) begin
        out_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_en && in_valid) begin
      item.point_x       <= point_x;
      item.point_y       <= point_y;
      item.outer_left    <= outer_left;
      item.outer_top     <= outer_top;
      item.outer_right   <= outer_right;
      item.outer_bottom  <= outer_bottom;
      item.client_width  <= client_width;
      item.client_height <= client_height;
      item.style_flags   <= style_flags;
      item.has_menu      <= has_menu;
      item.is_captured   <= is_captured;
    end
    if (out_en && item_valid) begin
      hit_code <= code;
    end
  end

  // The unit stalls its input only with both registers occupied.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (item_valid && out_valid && out_stall))
    else $error("input stalled with a free register");

  // A captured pointer always classifies as client.
  a_capture_is_client: assert property (@(posedge clk) disable iff (rst)
    (item_valid && out_en && item.is_captured) |=>
      (out_valid && hit_code == wfht_pkg::HIT_CLIENT))
    else $error("captured pointer not reported as client");

  // The containment tests leave no point for the error code.
  a_no_error_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit_code != wfht_pkg::HIT_ERROR))
    else $error("error hit code delivered");

endmodule

[tb/window_frame_hit_test_unit_test.sv]
`timescale 1ns / 1ps

module window_frame_hit_test_unit_test;
  import wfht_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOW_LIMIT  = 40;
  localparam int CMAX        = 2 ** (COORD_WIDTH - 1) - 1;
  localparam int CMIN        = -(2 ** (COORD_WIDTH - 1));

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [COORD_WIDTH-1:0] point_x = '0;
  logic signed [COORD_WIDTH-1:0] point_y = '0;
  logic signed [COORD_WIDTH-1:0] outer_left = '0;
  logic signed [COORD_WIDTH-1:0] outer_top = '0;
  logic signed [COORD_WIDTH-1:0] outer_right = '0;
  logic signed [COORD_WIDTH-1:0] outer_bottom = '0;
  logic [SIZE_WIDTH-1:0]         client_width = '0;
  logic [SIZE_WIDTH-1:0]         client_height = '0;
  logic [STYLE_WIDTH-1:0]        style_flags = '0;
  logic                          has_menu = 1'b0;
  logic                          is_captured = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [4:0]                    hit_code;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0]         paddr = '0;
  logic [DATA_WIDTH-1:0]         pwdata = '0;
  logic [DATA_WIDTH-1:0]         prdata;
  logic                          pready;

  window_frame_hit_test_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .point_x       (point_x),
    .point_y       (point_y),
    .outer_left    (outer_left),
    .outer_top     (outer_top),
    .outer_right   (outer_right),
    .outer_bottom  (outer_bottom),
    .client_width  (client_width),
    .client_height (client_height),
    .style_flags   (style_flags),
    .has_menu      (has_menu),
    .is_captured   (is_captured),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit_code      (hit_code),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  cfg_t       metrics_cfg = '{RST_VSCROLL_WIDTH, RST_HSCROLL_HEIGHT, RST_MENU_HEIGHT,
                              RST_CAPTION_HEIGHT, RST_BUTTON_WIDTH, RST_CORNER_HEIGHT};
  item_t      pointer_events[$];
  hit_code_t  expected_hits[$];
  item_t      current_event;
  hit_code_t  wanted_hit;
  int         send_idle_pct = 7;
  int         recv_idle_pct = 57;
  int         events_queued = 0;
  int         events_accepted = 0;
  int         hits_checked = 0;
  int         mismatches = 0;
  int         settings_run = 0;
  int         cycle_count = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d hit codes outstanding.",
               events_queued - hits_checked);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < SHOW_LIMIT)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic bit in_rect(longint x, longint y, longint l, longint t, longint r,
                                 longint b);
    return x >= l && x < r && y >= t && y < b;
  endfunction

  // Grows the client rectangle outward band by band, then falls back to the
  // sizing-border zones. All sums are held in 64 bits.
  function automatic hit_code_t classify_hit(item_t ev, cfg_t m);
    longint px, py, ol, ot, orr, ob, l, t, r, b, bw, chh, vw;
    logic [STYLE_WIDTH-1:0] st;
    px  = $signed(ev.point_x);
    py  = $signed(ev.point_y);
    ol  = $signed(ev.outer_left);
    ot  = $signed(ev.outer_top);
    orr = $signed(ev.outer_right);
    ob  = $signed(ev.outer_bottom);
    bw  = longint'(m.button_width);
    chh = longint'(m.corner_height);
    vw  = longint'(m.vscroll_width);
    st  = ev.style_flags;
    l = 0;
    t = 0;
    r = longint'(ev.client_width);
    b = longint'(ev.client_height);
    if (ev.is_captured) return HIT_CLIENT;
    if (!in_rect(px, py, ol, ot, orr, ob)) return HIT_NOWHERE;
    if (in_rect(px, py, l, t, r, b)) return HIT_CLIENT;
    if (st[ST_VSCROLL]) begin
      r += vw;
      if (in_rect(px, py, l, t, r, b)) return HIT_VSCROLL;
    end
    if (st[ST_HSCROLL]) begin
      b += longint'(m.hscroll_height);
      if (in_rect(px, py, l, t, r, b)) begin
        if (st[ST_VSCROLL] && px >= r - vw) return HIT_SIZEBOX;
        return HIT_HSCROLL;
      end
    end
    if (ev.has_menu) begin
      t -= longint'(m.menu_height) + 1;
      if (in_rect(px, py, l, t, r, b)) return HIT_MENU;
    end
    if (st[ST_BORDER] && st[ST_DLGFRAME]) begin
      t -= longint'(m.caption_height) - 1;
      if (in_rect(px, py, l, t, r, b)) begin
        // The system menu test is measured from the client origin.
        if (st[ST_SYSMENU] && px <= bw) return HIT_SYSMENU;
        if (st[ST_MAXBOX]) r -= bw + 1;
        if (px >= r) return HIT_MAXBUTTON;
        if (st[ST_MINBOX]) r -= bw + 1;
        if (px >= r) return HIT_MINBUTTON;
        return HIT_CAPTION;
      end
    end
    if (!st[ST_THICK] || (st[ST_DLGFRAME] && !st[ST_BORDER])) return HIT_BORDER;
    if (py < t) begin
      if (px < l + bw) return HIT_TOPLEFT;
      if (px >= r - bw) return HIT_TOPRIGHT;
      return HIT_TOP;
    end
    if (py >= b) begin
      if (px < l + bw) return HIT_BOTTOMLEFT;
      if (px >= r - bw) return HIT_BOTTOMRIGHT;
      return HIT_BOTTOM;
    end
    if (px < l) begin
      if (py < t + chh) return HIT_TOPLEFT;
      if (py >= b - chh) return HIT_BOTTOMLEFT;
      return HIT_LEFT;
    end
    if (px >= r) begin
      if (py < t + chh) return HIT_TOPRIGHT;
      if (py >= b - chh) return HIT_BOTTOMRIGHT;
      return HIT_RIGHT;
    end
    return HIT_ERROR;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] clamp_coord(int v);
    if (v > CMAX) return COORD_WIDTH'(CMAX);
    if (v < CMIN) return COORD_WIDTH'(CMIN);
    return COORD_WIDTH'(v);
  endfunction

  function automatic item_t make_event(int px, int py, int ol, int ot, int orr, int ob,
                                       int cw, int ch, logic [7:0] st, logic menu,
                                       logic cap);
    item_t ev;
    ev.point_x       = clamp_coord(px);
    ev.point_y       = clamp_coord(py);
    ev.outer_left    = clamp_coord(ol);
    ev.outer_top     = clamp_coord(ot);
    ev.outer_right   = clamp_coord(orr);
    ev.outer_bottom  = clamp_coord(ob);
    ev.client_width  = SIZE_WIDTH'(cw);
    ev.client_height = SIZE_WIDTH'(ch);
    ev.style_flags   = st;
    ev.has_menu      = menu;
    ev.is_captured   = cap;
    return ev;
  endfunction

  // Mostly a plausible window built around the current metrics, with the pointer
  // aimed near band and zone edges; the rest is raw noise over every field.
  function automatic item_t random_event();
    item_t ev;
    logic [7:0] st;
    logic menu;
    int cw, ch, bd, vw, hh, bw, top_menu, top_cap, rc, bc, ol, ot, orr, ob, px, py;
    int xs[7];
    int ys[8];
    if ($urandom_range(99, 0) < 15) begin
      ev.point_x       = COORD_WIDTH'($urandom);
      ev.point_y       = COORD_WIDTH'($urandom);
      ev.outer_left    = COORD_WIDTH'($urandom);
      ev.outer_top     = COORD_WIDTH'($urandom);
      ev.outer_right   = COORD_WIDTH'($urandom);
      ev.outer_bottom  = COORD_WIDTH'($urandom);
      ev.client_width  = SIZE_WIDTH'($urandom);
      ev.client_height = SIZE_WIDTH'($urandom);
      ev.style_flags   = STYLE_WIDTH'($urandom);
      ev.has_menu      = 1'($urandom);
      ev.is_captured   = 1'($urandom);
      return ev;
    end
    st = 8'($urandom);
    if ($urandom_range(99, 0) < 60) begin
      st[ST_BORDER]   = 1'b1;
      st[ST_DLGFRAME] = 1'b1;
    end
    if ($urandom_range(99, 0) < 70) st[ST_THICK] = 1'b1;
    menu = 1'($urandom);
    cw = ($urandom_range(9, 0) == 0) ? $urandom_range(CMAX, 0) : $urandom_range(300, 0);
    ch = ($urandom_range(9, 0) == 0) ? $urandom_range(CMAX, 0) : $urandom_range(300, 0);
    bd = $urandom_range(8, 0);
    vw = st[ST_VSCROLL] ? int'(metrics_cfg.vscroll_width) : 0;
    hh = st[ST_HSCROLL] ? int'(metrics_cfg.hscroll_height) : 0;
    bw = int'(metrics_cfg.button_width);
    top_menu = menu ? -(int'(metrics_cfg.menu_height) + 1) : 0;
    top_cap  = (st[ST_BORDER] && st[ST_DLGFRAME]) ?
               top_menu - (int'(metrics_cfg.caption_height) - 1) : top_menu;
    rc  = cw + vw;
    bc  = ch + hh;
    ol  = -bd - $urandom_range(2, 0);
    ot  = top_cap - bd - $urandom_range(2, 0);
    orr = rc + bd + $urandom_range(2, 0);
    ob  = bc + bd + $urandom_range(2, 0);
    xs = '{ol, 0, bw, cw, rc - (bw + 1), rc - 2 * (bw + 1), orr};
    ys = '{ot, top_cap, top_menu, 0, ch, ob, top_cap + int'(metrics_cfg.corner_height),
           bc - int'(metrics_cfg.corner_height)};
    if ($urandom_range(1, 0)) px = ol - 3 + $urandom_range(orr - ol + 6, 0);
    else px = xs[$urandom_range(6, 0)] + $urandom_range(6, 0) - 3;
    if ($urandom_range(1, 0)) py = ot - 3 + $urandom_range(ob - ot + 6, 0);
    else py = ys[$urandom_range(7, 0)] + $urandom_range(6, 0) - 3;
    return make_event(px, py, ol, ot, orr, ob, cw, ch, st, menu,
                      $urandom_range(19, 0) == 0);
  endfunction

  // Sender side: one transaction in flight, reloaded from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_hits.push_back(classify_hit(current_event, metrics_cfg));
        events_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pointer_events.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          current_event = pointer_events.pop_front();
          point_x       <= current_event.point_x;
          point_y       <= current_event.point_y;
          outer_left    <= current_event.outer_left;
          outer_top     <= current_event.outer_top;
          outer_right   <= current_event.outer_right;
          outer_bottom  <= current_event.outer_bottom;
          client_width  <= current_event.client_width;
          client_height <= current_event.client_height;
          style_flags   <= current_event.style_flags;
          has_menu      <= current_event.has_menu;
          is_captured   <= current_event.is_captured;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side: checks each completed result transaction in order.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          report_mismatch($sformatf("hit code %0d arrived with nothing expected", hit_code));
        end else begin
          wanted_hit = expected_hits.pop_front();
          if (hit_code !== wanted_hit)
            report_mismatch($sformatf("hit code %0d, expected %0d (%s)", hit_code,
                                      wanted_hit, wanted_hit.name()));
          hits_checked++;
        end
      end
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  task automatic write_metric(input logic [IDX_WIDTH-1:0] idx, input logic [7:0] value);
    logic [DATA_WIDTH-1:0] word;
    word = $urandom;
    word[7:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_VSCROLL_WIDTH:  metrics_cfg.vscroll_width  = value;
      REG_HSCROLL_HEIGHT: metrics_cfg.hscroll_height = value;
      REG_MENU_HEIGHT:    metrics_cfg.menu_height    = value;
      REG_CAPTION_HEIGHT: metrics_cfg.caption_height = value;
      REG_BUTTON_WIDTH:   metrics_cfg.button_width   = value;
      REG_CORNER_HEIGHT:  metrics_cfg.corner_height  = value;
      default: ;
    endcase
  endtask

  task automatic write_all_metrics(input logic [7:0] vw, input logic [7:0] hh,
                                   input logic [7:0] mh, input logic [7:0] cap,
                                   input logic [7:0] bw, input logic [7:0] chh);
    write_metric(REG_VSCROLL_WIDTH, vw);
    write_metric(REG_HSCROLL_HEIGHT, hh);
    write_metric(REG_MENU_HEIGHT, mh);
    write_metric(REG_CAPTION_HEIGHT, cap);
    write_metric(REG_BUTTON_WIDTH, bw);
    write_metric(REG_CORNER_HEIGHT, chh);
  endtask

  task automatic queue_event(input item_t ev);
    pointer_events.push_back(ev);
    events_queued++;
  endtask

  // Waits until every queued transaction has been accepted and answered.
  task automatic drain();
    while (events_accepted < events_queued || expected_hits.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) queue_event(random_event());
    drain();
    settings_run++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset metrics: a window of 200 x 100 with every style bit, a menu and a
    // caption, so the bands run from -38 to 116 and the frame is 4 wide.
    queue_event(make_event(500, 500, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b1));
    queue_event(make_event(-5, 50, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(0, 0, 0, -42, 0, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(10, 10, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(205, 10, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(10, 105, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(205, 105, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(10, -5, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(18, -30, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(200, -30, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(180, -30, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(100, -30, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    // Maximise box disabled: its test still runs against the unmoved edge.
    queue_event(make_event(200, -30, -4, -42, 220, 120, 200, 100, 8'hDF, 1'b1, 1'b0));
    queue_event(make_event(-2, 50, -4, -42, 220, 120, 200, 100, 8'h7F, 1'b1, 1'b0));
    queue_event(make_event(-2, 50, -4, -42, 220, 120, 200, 100, 8'h8B, 1'b1, 1'b0));
    queue_event(make_event(-3, -40, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(215, -40, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(100, -40, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(-3, 118, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(100, 118, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(218, 118, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(-3, 50, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(218, 50, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(-3, -30, -4, -42, 220, 120, 200, 100, 8'hFF, 1'b1, 1'b0));
    queue_event(make_event(CMIN, CMAX - 1, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, 8'h00,
                           1'b0, 1'b0));
    queue_event(make_event(CMAX - 1, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, 8'hFF,
                           1'b1, 1'b0));
    run_random(170);

    // All metrics zero, so the caption band moves down by one row.
    write_all_metrics(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_random(190);

    send_idle_pct = 57;
    recv_idle_pct = 7;
    write_all_metrics(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    run_random(190);
    write_all_metrics(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                      8'($urandom_range(255, 0)), 8'($urandom_range(255, 1)),
                      8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
    run_random(190);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all_metrics(8'($urandom_range(8, 0)), 8'($urandom_range(8, 0)),
                      8'($urandom_range(8, 0)), 8'($urandom_range(8, 1)),
                      8'($urandom_range(8, 0)), 8'($urandom_range(8, 0)));
    run_random(190);
    write_all_metrics(RST_VSCROLL_WIDTH, RST_HSCROLL_HEIGHT, RST_MENU_HEIGHT, 8'd1,
                      RST_BUTTON_WIDTH, RST_CORNER_HEIGHT);
    run_random(190);

    if (expected_hits.size() != 0)
      report_mismatch($sformatf("%0d hit codes never arrived", expected_hits.size()));
    $display("Checked %0d hit codes from %0d pointer events over %0d metric settings,",
             hits_checked, events_accepted, settings_run);
    $display("including all-zero and all-ones metrics, under three idling patterns.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
